### src/srpp_pkg.sv
`timescale 1ns / 1ps

package srpp_pkg;

  localparam int FIELD_DIGITS = 4;

  localparam logic [3:0] POS_VOLT_END = 4'(FIELD_DIGITS);
  localparam logic [3:0] POS_CURR_END = 4'(2 * FIELD_DIGITS);
  localparam logic [3:0] POS_MAX      = 4'd15;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_O   = 8'h4F;
  localparam logic [7:0] CHAR_K   = 8'h4B;
  localparam logic [7:0] CHAR_ONE = 8'h31;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_9   = 8'h39;

  localparam logic [13:0] ACC_MAX = 14'd16383;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] REG_ACQUIRE_ENABLE = 2'd0;
  localparam logic [1:0] REG_SAMPLE_LIMIT   = 2'd1;
  localparam logic [1:0] REG_TIME_LIMIT     = 2'd2;
  localparam logic [1:0] REG_REPLY_TIMEOUT  = 2'd3;

  localparam logic [15:0] REPLY_TIMEOUT_RESET = 16'd500;

  // decoded reply handed from the parser to the poller
  typedef struct packed {
    logic        done;
    logic [13:0] volt;
    logic [13:0] curr;
    logic        cc;
  } sample_t;

  typedef struct packed {
    logic        send_request;
    logic        sample_valid;
    logic [13:0] volt;
    logic [13:0] curr;
    logic        cc;
    logic        stopped;
  } result_t;

endpackage

### src/srpp_parser.sv
`timescale 1ns / 1ps

module srpp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                command,
  input  logic [7:0]          rx_byte,
  output srpp_pkg::sample_t   sample
);

  logic [3:0]  pos, pos_next;
  logic        seen_cr, seen_cr_next;
  logic [15:0] hist, hist_next;
  logic [13:0] vacc, vacc_next;
  logic [13:0] cacc, cacc_next;
  logic [1:0]  ended, ended_next;
  logic        mode, mode_next;
  logic        is_digit;
  logic        byte_step;

  function automatic logic [13:0] push_digit(input logic [13:0] acc, input logic [3:0] d);
    logic [17:0] v;
    v = 18'(acc) * 18'd10 + 18'(d);
    return (v > 18'(srpp_pkg::ACC_MAX)) ? srpp_pkg::ACC_MAX : v[13:0];
  endfunction

  assign byte_step = step && (command == srpp_pkg::CMD_BYTE);
  assign is_digit  = (rx_byte >= srpp_pkg::CHAR_0) && (rx_byte <= srpp_pkg::CHAR_9);

  always_comb begin
    pos_next     = pos;
    seen_cr_next = seen_cr;
    hist_next    = hist;
    vacc_next    = vacc;
    cacc_next    = cacc;
    ended_next   = ended;
    mode_next    = mode;

    sample.done = byte_step && (hist == {srpp_pkg::CHAR_O, srpp_pkg::CHAR_K})
                  && (rx_byte == srpp_pkg::CHAR_CR);
    sample.volt = vacc;
    sample.curr = cacc;
    sample.cc   = mode;

    if (sample.done) begin
      pos_next     = '0;
      seen_cr_next = 1'b0;
      hist_next    = '0;
      vacc_next    = '0;
      cacc_next    = '0;
      ended_next   = '0;
      mode_next    = 1'b0;
    end else if (byte_step) begin
      if (rx_byte == srpp_pkg::CHAR_CR) begin
        seen_cr_next = 1'b1;
      end else if (!seen_cr) begin
        if (pos < srpp_pkg::POS_VOLT_END) begin
          if (!ended[0]) begin
            if (is_digit) vacc_next = push_digit(vacc, rx_byte[3:0]);
            else ended_next[0] = 1'b1;
          end
        end else if (pos < srpp_pkg::POS_CURR_END) begin
          if (!ended[1]) begin
            if (is_digit) cacc_next = push_digit(cacc, rx_byte[3:0]);
            else ended_next[1] = 1'b1;
          end
        end else if (pos == srpp_pkg::POS_CURR_END) begin
          mode_next = (rx_byte == srpp_pkg::CHAR_ONE);
        end
      end
      if (pos < srpp_pkg::POS_MAX) pos_next = pos + 4'd1;
      hist_next = {hist[7:0], rx_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      seen_cr <= 1'b0;
      hist    <= '0;
      vacc    <= '0;
      cacc    <= '0;
      ended   <= '0;
      mode    <= 1'b0;
    end else begin
      pos     <= pos_next;
      seen_cr <= seen_cr_next;
      hist    <= hist_next;
      vacc    <= vacc_next;
      cacc    <= cacc_next;
      ended   <= ended_next;
      mode    <= mode_next;
    end
  end

endmodule

### src/supply_reply_parser_poller.sv
`timescale 1ns / 1ps

// Reply parser and poller for a bench supply on a serial link.
// Input channel (in_valid / in_stall): command selects a received byte
// (rx_byte) or a one millisecond tick. Output channel (out_valid /
// out_stall): exactly one result per input request, carrying send_request,
// the decoded sample (sample_valid, voltage, current, cc_mode) and stopped.
// Each request is handled in the cycle it is accepted and its result is
// registered; one request is taken every cycle while in_stall is low.
// A two-entry output buffer (result register plus skid register) lets a
// request be accepted while the previous result waits; in_stall rises only
// when both entries are full, i.e. while the receiver keeps out_stall high.
// Configuration is written through cfg_write / cfg_index / cfg_data; the user
// must write it only while the block is idle; the block does not enforce it.
// Reset clears all parse, poll and limit state, drops both buffer entries,
// sets acquire_enable and both limits to zero, the reply timeout to 500 ticks.
// Once a sample or time limit trips, every result reads stopped until reset.
module supply_reply_parser_poller (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        send_request,
  output logic        sample_valid,
  output logic [13:0] voltage_centivolts,
  output logic [13:0] current_centiamps,
  output logic        cc_mode,
  output logic        stopped,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic        acquire_enable;
  logic [31:0] sample_limit;
  logic [31:0] time_limit_ticks;
  logic [15:0] reply_timeout_ticks;

  logic        pending, pending_next;
  logic [15:0] wait_ticks, wait_ticks_next;
  logic [31:0] sample_count, sample_count_next;
  logic [31:0] elapsed, elapsed_next;
  logic        halted, halted_next;

  logic                accept;
  logic                step;
  logic                tick;
  srpp_pkg::sample_t   sample;
  srpp_pkg::result_t   res;
  srpp_pkg::result_t   out_reg;
  srpp_pkg::result_t   skid_reg;
  logic                skid_valid;
  logic                out_take;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign step     = accept && !halted;
  assign tick     = step && (command == srpp_pkg::CMD_TICK);

  srpp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .command (command),
    .rx_byte (rx_byte),
    .sample  (sample)
  );

  always_comb begin
    sample_count_next = sample_count;
    elapsed_next      = elapsed;
    wait_ticks_next   = wait_ticks;
    pending_next      = pending;
    halted_next       = halted;
    res               = '0;

    if (halted) begin
      res.stopped = 1'b1;
    end else begin
      if (sample.done && sample_count != '1) sample_count_next = sample_count + 32'd1;
      if (tick && elapsed != '1) elapsed_next = elapsed + 32'd1;
      if (tick && pending && wait_ticks != '1) wait_ticks_next = wait_ticks + 16'd1;
      if (sample.done) pending_next = 1'b0;

      res.sample_valid = sample.done;
      if (sample.done) begin
        res.volt = sample.volt;
        res.curr = sample.curr;
        res.cc   = sample.cc;
      end

      priority if (sample_limit != '0 && sample_count_next >= sample_limit) begin
        halted_next = 1'b1;
      end else if (time_limit_ticks != '0 && elapsed_next > time_limit_ticks) begin
        halted_next = 1'b1;
      end else if (acquire_enable) begin
        if (pending_next) begin
          if (wait_ticks_next > reply_timeout_ticks) pending_next = 1'b0;
        end else begin
          res.send_request = 1'b1;
          pending_next     = 1'b1;
          wait_ticks_next  = '0;
        end
      end
      res.stopped = halted_next;
    end
  end

  // poll and limit state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending      <= 1'b0;
      wait_ticks   <= '0;
      sample_count <= '0;
      elapsed      <= '0;
      halted       <= 1'b0;
    end else if (accept) begin
      pending      <= pending_next;
      wait_ticks   <= wait_ticks_next;
      sample_count <= sample_count_next;
      elapsed      <= elapsed_next;
      halted       <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acquire_enable      <= 1'b0;
      sample_limit        <= '0;
      time_limit_ticks    <= '0;
      reply_timeout_ticks <= srpp_pkg::REPLY_TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        srpp_pkg::REG_ACQUIRE_ENABLE: acquire_enable      <= cfg_data[0];
        srpp_pkg::REG_SAMPLE_LIMIT:   sample_limit        <= cfg_data;
        srpp_pkg::REG_TIME_LIMIT:     time_limit_ticks    <= cfg_data;
        srpp_pkg::REG_REPLY_TIMEOUT:  reply_timeout_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // result register with a skid entry behind it
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) out_reg <= skid_reg;
      else if (accept) out_reg <= res;
    end else if (accept) begin
      skid_reg <= res;
    end
  end

  assign send_request       = out_reg.send_request;
  assign sample_valid       = out_reg.sample_valid;
  assign voltage_centivolts = out_reg.volt;
  assign current_centiamps  = out_reg.curr;
  assign cc_mode            = out_reg.cc;
  assign stopped            = out_reg.stopped;

endmodule
